// File: design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and the lead-byte decode function for the UTF-8 to
// UTF-16 decoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

  // Code point constants
  localparam logic [20:0] REPL_CHAR     = 21'h00FFFD;
  localparam logic [20:0] MAX_POINT     = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST    = 21'h00D800;
  localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
  localparam logic [20:0] HI_SURR_BASE  = 21'h00D800;
  localparam logic [20:0] LO_SURR_BASE  = 21'h00DC00;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] BMP_LAST      = 21'h00FFFF;
  localparam logic [20:0] MIN_TWO_BYTE  = 21'h000080;
  localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;

  // Continuation counts of a sequence
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // One result beat
  typedef struct packed {
    logic [20:0] code_unit;
    logic        is_replacement;
    logic        last_of_run;
  } result_t;

  // Sequence tracking state
  typedef struct packed {
    logic [20:0] partial_point;
    logic [1:0]  bytes_due;
    logic [1:0]  sequence_length;
  } state_t;

  // Outcome of decoding a byte from the idle state
  typedef struct packed {
    logic    emit;
    result_t res;
    state_t  nxt;
  } start_t;

  // Decoder to result buffer: up to two results and the next state
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
    state_t     nxt;
  } dec_out_t;

  // Decode a byte with no sequence pending
  function automatic start_t start_decode(input logic [7:0] b, input logic eot);
    start_t      r;
    logic        is_lead;
    logic [1:0]  extra;
    logic [20:0] bits;
    r       = '0;
    is_lead = 1'b0;
    extra   = SEQ_NONE;
    bits    = '0;
    if (!b[7]) begin
      r.emit          = 1'b1;
      r.res.code_unit = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      is_lead = 1'b1;
      extra   = SEQ_TWO;
      bits    = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      is_lead = 1'b1;
      extra   = SEQ_THREE;
      bits    = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      is_lead = 1'b1;
      extra   = SEQ_FOUR;
      bits    = {18'd0, b[2:0]};
    end else begin
      // stray continuation or 0xF8..0xFF
      r.emit               = 1'b1;
      r.res.code_unit      = REPL_CHAR;
      r.res.is_replacement = 1'b1;
    end
    if (is_lead) begin
      if (eot) begin
        r.emit               = 1'b1;
        r.res.code_unit      = REPL_CHAR;
        r.res.is_replacement = 1'b1;
      end else begin
        r.nxt.partial_point   = bits;
        r.nxt.bytes_due       = extra;
        r.nxt.sequence_length = extra;
      end
    end
    return r;
  endfunction

endpackage

// File: design/utf8_to_utf16_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// A byte's first result beat is presented in the cycle after it is accepted.
// Throughput: one byte per cycle while out_ready is high; a byte giving two
// beats (surrogate pair, or a cut sequence plus the restarted byte) holds the
// input while both are in the two-entry result buffer with its single output port.
// Reset: synchronous active-low; clears sequence state, wide mode and buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_unit,
  output logic        out_is_replacement,
  output logic        out_last_of_run
);

  u8u16_pkg::state_t   state_r;
  u8u16_pkg::state_t   state_nxt;
  logic                wide_r;
  logic                push;
  u8u16_pkg::dec_out_t dec;
  u8u16_pkg::result_t  out_res;

  assign push = in_valid && in_ready;

  // Byte decoder
  u8u16_decode u_decode (
    .st             (state_r),
    .wide_mode      (wide_r),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .dec            (dec)
  );

  // Result buffer
  u8u16_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .dec       (dec),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_code_unit      = out_res.code_unit;
  assign out_is_replacement = out_res.is_replacement;
  assign out_last_of_run    = out_res.last_of_run;

  // Sequence state advances on every accepted byte
  assign state_nxt = push ? dec.nxt : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else if (cfg_we) begin
      wide_r <= cfg_wdata;
    end
  end

endmodule

// File: design/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Combinational byte decoder: from the sequence state and one input byte it
// forms up to two result beats and the next sequence state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_decode (
  input  u8u16_pkg::state_t   st,
  input  logic                wide_mode,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_text,
  output u8u16_pkg::dec_out_t dec
);

  logic                 is_cont;
  logic [20:0]          cont_pp;
  logic [1:0]           due_m1;
  logic                 overlong;
  logic                 bad_point;
  logic [20:0]          off;
  u8u16_pkg::start_t    sb;

  assign is_cont = (in_byte[7:6] == 2'b10);
  assign cont_pp = {st.partial_point[14:0], in_byte[5:0]};
  assign due_m1  = st.bytes_due - 2'd1;
  assign off     = cont_pp - u8u16_pkg::SUPP_BASE;
  assign sb      = u8u16_pkg::start_decode(in_byte, in_end_of_text);

  // Overlong check against the sequence length
  always_comb begin
    unique case (st.sequence_length)
      u8u16_pkg::SEQ_TWO:   overlong = (cont_pp < u8u16_pkg::MIN_TWO_BYTE);
      u8u16_pkg::SEQ_THREE: overlong = (cont_pp < u8u16_pkg::MIN_THREE_BYTE);
      u8u16_pkg::SEQ_FOUR:  overlong = (cont_pp < u8u16_pkg::SUPP_BASE);
      default:              overlong = 1'b0;
    endcase
  end

  assign bad_point = overlong
                   || ((cont_pp >= u8u16_pkg::SURR_FIRST) && (cont_pp <= u8u16_pkg::SURR_LAST))
                   || (cont_pp > u8u16_pkg::MAX_POINT);

  // Result selection and next state
  always_comb begin
    dec     = '0;
    dec.nxt = st;
    if (st.bytes_due != u8u16_pkg::SEQ_NONE) begin
      if (is_cont) begin
        if (due_m1 == u8u16_pkg::SEQ_NONE) begin
          // sequence complete
          dec.nxt = '0;
          if (bad_point) begin
            dec.count               = 2'd1;
            dec.res0.code_unit      = u8u16_pkg::REPL_CHAR;
            dec.res0.is_replacement = 1'b1;
          end else if (!wide_mode && (cont_pp > u8u16_pkg::BMP_LAST)) begin
            dec.count          = 2'd2;
            dec.res0.code_unit = u8u16_pkg::HI_SURR_BASE + {11'd0, off[19:10]};
            dec.res1.code_unit = u8u16_pkg::LO_SURR_BASE + {11'd0, off[9:0]};
          end else begin
            dec.count          = 2'd1;
            dec.res0.code_unit = cont_pp;
          end
        end else if (in_end_of_text) begin
          // text ends mid-sequence
          dec.nxt                 = '0;
          dec.count               = 2'd1;
          dec.res0.code_unit      = u8u16_pkg::REPL_CHAR;
          dec.res0.is_replacement = 1'b1;
        end else begin
          dec.nxt.partial_point = cont_pp;
          dec.nxt.bytes_due     = due_m1;
        end
      end else begin
        // sequence cut short; the cutting byte is decoded afresh
        dec.res0.code_unit      = u8u16_pkg::REPL_CHAR;
        dec.res0.is_replacement = 1'b1;
        dec.res1                = sb.res;
        dec.count               = sb.emit ? 2'd2 : 2'd1;
        dec.nxt                 = sb.nxt;
      end
    end else begin
      dec.count = {1'b0, sb.emit};
      dec.res0  = sb.res;
      dec.nxt   = sb.nxt;
    end
    // mark the final beat caused by this byte
    if (dec.count == 2'd1) begin
      dec.res0.last_of_run = 1'b1;
    end else if (dec.count == 2'd2) begin
      dec.res1.last_of_run = 1'b1;
    end
  end

endmodule

// File: design/u8u16_outbuf.sv
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Two-entry result buffer. Loads all beats of one byte at once and drains
// them in order; takes a new byte whenever it will be empty at the edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8u16_pkg::dec_out_t dec,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output u8u16_pkg::result_t  out_res
);

  u8u16_pkg::result_t slot0_r, slot0_nxt;
  u8u16_pkg::result_t slot1_r, slot1_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot0_r;
  assign pop       = out_valid && out_ready;
  assign can_push  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  // Next buffer contents
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (push) begin
      slot0_nxt = dec.res0;
      slot1_nxt = dec.res1;
      cnt_nxt   = dec.count;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
